[hw/rtl/escape_time_fractal_iterator_core_macros.svh]
// assertion helpers used by the checker file
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_CORE_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define EFI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("efi check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define EFI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("efi check failed");

`endif

[hw/rtl/efi_pkg.sv]
package efi_pkg;

  localparam int FRAC_BITS    = 28;
  localparam int COORD_BITS   = 12;
  localparam int COUNT_BITS   = 10;
  localparam int TYPE_BITS    = 4;
  localparam int CFG_IDX_BITS = 3;

  localparam int CBITS  = FRAC_BITS + 4;
  localparam int WFRAC  = FRAC_BITS + 8;
  localparam int WBITS  = FRAC_BITS + 20;
  localparam int CSHIFT = WFRAC - FRAC_BITS;
  localparam int HALF   = (WBITS + 1) / 2;
  localparam int ACCW   = 4 * HALF;
  localparam int PRODW  = COORD_BITS + CBITS - 1;
  localparam int SUMW   = PRODW + 2;
  localparam int PC_BITS = 6;

  typedef logic signed [WBITS-1:0] word_t;

  localparam word_t W_MAX = {1'b0, {(WBITS-1){1'b1}}};
  localparam word_t W_MIN = {1'b1, {(WBITS-1){1'b0}}};
  localparam longint W_ONE = longint'(1) <<< WFRAC;
  localparam logic signed [WBITS:0] ESC_LIMIT = (WBITS+1)'(25 * W_ONE);

  // round-half-up of milli * 2^WFRAC / 1000
  function automatic longint kfix(longint milli);
    return (milli * W_ONE + 64'sd500) / 64'sd1000;
  endfunction

  localparam word_t K_J_RE = word_t'(-kfix(835));
  localparam word_t K_J_IM = word_t'(-kfix(232));
  localparam word_t K_F_RE = word_t'(-kfix(530));
  localparam word_t K_F_IM = word_t'(kfix(267));
  localparam word_t K_X_RE = word_t'(-kfix(372));
  localparam word_t K_X_IM = word_t'(kfix(519));

  // register map
  localparam logic [CFG_IDX_BITS-1:0] CFG_TYPE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MINR  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAXI  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RSTEP = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ISTEP = 3'd5;

  localparam logic [COUNT_BITS-1:0] DEPTH_RST = COUNT_BITS'(64);
  localparam logic [CBITS-1:0] MINR_RST = CBITS'(-(longint'(2) <<< FRAC_BITS));
  localparam logic [CBITS-1:0] MAXI_RST = CBITS'(longint'(2) <<< FRAC_BITS);
  localparam logic [CBITS-2:0] STEP_RST =
    (CBITS-1)'(((longint'(4) <<< FRAC_BITS) + 64'sd255) / 64'sd511);

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [COUNT_BITS-1:0] escape_count;
  } pix_out_t;

  typedef enum logic [TYPE_BITS-1:0] {
    RULE_M, RULE_B, RULE_J, RULE_T, RULE_S, RULE_V, RULE_F, RULE_R, RULE_X, RULE_C
  } rule_e;

  // complex-level microcode
  typedef enum logic [2:0] {
    COP_MUL, COP_ADD, COP_SUB, COP_NEG, COP_ABS, COP_ADDK, COP_CHK, COP_NOP
  } cop_e;

  // real-level micro-ops issued to the datapath
  typedef enum logic [2:0] {
    ROP_MUL, ROP_ADD, ROP_SUB, ROP_NEG, ROP_ABS, ROP_ADDK, ROP_CHK, ROP_NOP
  } rop_e;

  typedef enum logic [1:0] {K_JULIA, K_F, K_X} kc_e;

  // complex register pairs in the register file
  localparam logic [2:0] CZ = 3'd0;
  localparam logic [2:0] CC = 3'd1;
  localparam logic [2:0] CS = 3'd2;
  localparam logic [2:0] CA = 3'd3;
  localparam logic [2:0] CB = 3'd4;
  localparam logic [2:0] CE = 3'd5;
  localparam logic [2:0] CG = 3'd6;
  localparam logic [2:0] CI = 3'd7;

  typedef struct packed {
    cop_e       op;
    logic       last;
    logic [2:0] d;
    logic [2:0] a;
    logic       sa;
    logic [2:0] b;
    logic       sb;
    kc_e        k;
  } cinstr_t;

  typedef struct packed {
    rop_e       op;
    logic [3:0] dst;
    logic [3:0] ra;
    logic [3:0] rb;
    kc_e        k;
    logic       fin;
  } uop_t;

  localparam logic [PC_BITS-1:0] PC_CHK = 6'd0;
  localparam logic [PC_BITS-1:0] PC_M   = 6'd1;
  localparam logic [PC_BITS-1:0] PC_B   = 6'd3;
  localparam logic [PC_BITS-1:0] PC_J   = 6'd6;
  localparam logic [PC_BITS-1:0] PC_T   = 6'd8;
  localparam logic [PC_BITS-1:0] PC_S   = 6'd12;
  localparam logic [PC_BITS-1:0] PC_V   = 6'd16;
  localparam logic [PC_BITS-1:0] PC_F   = 6'd19;
  localparam logic [PC_BITS-1:0] PC_R   = 6'd25;
  localparam logic [PC_BITS-1:0] PC_X   = 6'd33;
  localparam logic [PC_BITS-1:0] PC_C   = 6'd37;
  localparam logic [PC_BITS-1:0] PC_NOP = 6'd41;

  function automatic cinstr_t ci(cop_e op, logic last, logic [2:0] d, logic [2:0] a,
                                 logic sa, logic [2:0] b, logic sb, kc_e k);
    cinstr_t r;
    r.op = op; r.last = last; r.d = d; r.a = a; r.sa = sa; r.b = b; r.sb = sb; r.k = k;
    return r;
  endfunction

  function automatic cinstr_t prog(logic [PC_BITS-1:0] pc);
    case (pc)
      // escape test on z
      6'd0:  return ci(COP_CHK,  1'b0, CS, CZ, 1'b0, CZ, 1'b0, K_JULIA);
      // z^2 + c
      6'd1:  return ci(COP_MUL,  1'b0, CA, CZ, 1'b0, CZ, 1'b0, K_JULIA);
      6'd2:  return ci(COP_ADD,  1'b1, CZ, CA, 1'b0, CC, 1'b0, K_JULIA);
      // abs(z)^2 + c
      6'd3:  return ci(COP_ABS,  1'b0, CA, CZ, 1'b0, CZ, 1'b0, K_JULIA);
      6'd4:  return ci(COP_MUL,  1'b0, CB, CA, 1'b0, CA, 1'b0, K_JULIA);
      6'd5:  return ci(COP_ADD,  1'b1, CZ, CB, 1'b0, CC, 1'b0, K_JULIA);
      // z^2 + k
      6'd6:  return ci(COP_MUL,  1'b0, CA, CZ, 1'b0, CZ, 1'b0, K_JULIA);
      6'd7:  return ci(COP_ADDK, 1'b1, CZ, CA, 1'b0, CZ, 1'b0, K_JULIA);
      // z^4 + c
      6'd8:  return ci(COP_MUL,  1'b0, CA, CZ, 1'b0, CZ, 1'b0, K_JULIA);
      6'd9:  return ci(COP_MUL,  1'b0, CB, CA, 1'b0, CZ, 1'b0, K_JULIA);
      6'd10: return ci(COP_MUL,  1'b0, CA, CB, 1'b0, CZ, 1'b0, K_JULIA);
      6'd11: return ci(COP_ADD,  1'b1, CZ, CA, 1'b0, CC, 1'b0, K_JULIA);
      // neg(z)^3 + swap(c)
      6'd12: return ci(COP_NEG,  1'b0, CE, CZ, 1'b0, CZ, 1'b0, K_JULIA);
      6'd13: return ci(COP_MUL,  1'b0, CA, CE, 1'b0, CE, 1'b0, K_JULIA);
      6'd14: return ci(COP_MUL,  1'b0, CB, CA, 1'b0, CE, 1'b0, K_JULIA);
      6'd15: return ci(COP_ADD,  1'b1, CZ, CB, 1'b0, CC, 1'b1, K_JULIA);
      // neg(swap(z))^2 + z
      6'd16: return ci(COP_NEG,  1'b0, CE, CZ, 1'b1, CZ, 1'b0, K_JULIA);
      6'd17: return ci(COP_MUL,  1'b0, CA, CE, 1'b0, CE, 1'b0, K_JULIA);
      6'd18: return ci(COP_ADD,  1'b1, CZ, CA, 1'b0, CZ, 1'b0, K_JULIA);
      // neg(swap(abs(z)))^2 - c^2 + k
      6'd19: return ci(COP_ABS,  1'b0, CE, CZ, 1'b0, CZ, 1'b0, K_F);
      6'd20: return ci(COP_NEG,  1'b0, CG, CE, 1'b1, CZ, 1'b0, K_F);
      6'd21: return ci(COP_MUL,  1'b0, CA, CG, 1'b0, CG, 1'b0, K_F);
      6'd22: return ci(COP_MUL,  1'b0, CB, CC, 1'b0, CC, 1'b0, K_F);
      6'd23: return ci(COP_SUB,  1'b0, CA, CA, 1'b0, CB, 1'b0, K_F);
      6'd24: return ci(COP_ADDK, 1'b1, CZ, CA, 1'b0, CZ, 1'b0, K_F);
      // z^3 + z*c^2 - c^3 - z
      6'd25: return ci(COP_MUL,  1'b0, CA, CZ, 1'b0, CZ, 1'b0, K_JULIA);
      6'd26: return ci(COP_MUL,  1'b0, CB, CA, 1'b0, CZ, 1'b0, K_JULIA);
      6'd27: return ci(COP_MUL,  1'b0, CE, CC, 1'b0, CC, 1'b0, K_JULIA);
      6'd28: return ci(COP_MUL,  1'b0, CG, CZ, 1'b0, CE, 1'b0, K_JULIA);
      6'd29: return ci(COP_ADD,  1'b0, CB, CB, 1'b0, CG, 1'b0, K_JULIA);
      6'd30: return ci(COP_MUL,  1'b0, CI, CE, 1'b0, CC, 1'b0, K_JULIA);
      6'd31: return ci(COP_SUB,  1'b0, CB, CB, 1'b0, CI, 1'b0, K_JULIA);
      6'd32: return ci(COP_SUB,  1'b1, CZ, CB, 1'b0, CZ, 1'b0, K_JULIA);
      // (z^2 - z^3) + k
      6'd33: return ci(COP_MUL,  1'b0, CA, CZ, 1'b0, CZ, 1'b0, K_X);
      6'd34: return ci(COP_MUL,  1'b0, CB, CA, 1'b0, CZ, 1'b0, K_X);
      6'd35: return ci(COP_SUB,  1'b0, CA, CA, 1'b0, CB, 1'b0, K_X);
      6'd36: return ci(COP_ADDK, 1'b1, CZ, CA, 1'b0, CZ, 1'b0, K_X);
      // z^4 + k
      6'd37: return ci(COP_MUL,  1'b0, CA, CZ, 1'b0, CZ, 1'b0, K_JULIA);
      6'd38: return ci(COP_MUL,  1'b0, CB, CA, 1'b0, CZ, 1'b0, K_JULIA);
      6'd39: return ci(COP_MUL,  1'b0, CA, CB, 1'b0, CZ, 1'b0, K_JULIA);
      6'd40: return ci(COP_ADDK, 1'b1, CZ, CA, 1'b0, CZ, 1'b0, K_JULIA);
      // unused selector: z held
      default: return ci(COP_NOP, 1'b1, CZ, CZ, 1'b0, CZ, 1'b0, K_JULIA);
    endcase
  endfunction

  function automatic logic [PC_BITS-1:0] rule_start(logic [TYPE_BITS-1:0] t);
    case (rule_e'(t))
      RULE_M:  return PC_M;
      RULE_B:  return PC_B;
      RULE_J:  return PC_J;
      RULE_T:  return PC_T;
      RULE_S:  return PC_S;
      RULE_V:  return PC_V;
      RULE_F:  return PC_F;
      RULE_R:  return PC_R;
      RULE_X:  return PC_X;
      RULE_C:  return PC_C;
      default: return PC_NOP;
    endcase
  endfunction

  // break one complex op into its real steps
  function automatic uop_t expand(cinstr_t c, logic [2:0] sub);
    uop_t u;
    logic [3:0] are, aim, bre, bim, dre, dim, s0, s1;
    are = {c.a, c.sa};
    aim = {c.a, ~c.sa};
    bre = {c.b, c.sb};
    bim = {c.b, ~c.sb};
    dre = {c.d, 1'b0};
    dim = {c.d, 1'b1};
    s0  = {CS, 1'b0};
    s1  = {CS, 1'b1};
    u.op  = ROP_NOP;
    u.dst = dre;
    u.ra  = are;
    u.rb  = bre;
    u.k   = c.k;
    u.fin = 1'b0;
    case (c.op)
      COP_MUL: begin
        case (sub)
          3'd0: begin u.op = ROP_MUL; u.dst = s0; u.ra = are; u.rb = bre; end
          3'd1: begin u.op = ROP_MUL; u.dst = s1; u.ra = aim; u.rb = bim; end
          3'd2: begin u.op = ROP_SUB; u.dst = dre; u.ra = s0; u.rb = s1; end
          3'd3: begin u.op = ROP_MUL; u.dst = s0; u.ra = are; u.rb = bim; end
          3'd4: begin u.op = ROP_MUL; u.dst = s1; u.ra = aim; u.rb = bre; end
          default: begin
            u.op = ROP_ADD; u.dst = dim; u.ra = s0; u.rb = s1; u.fin = 1'b1;
          end
        endcase
      end
      COP_CHK: begin
        case (sub)
          3'd0: begin u.op = ROP_MUL; u.dst = s0; u.ra = are; u.rb = are; end
          3'd1: begin u.op = ROP_MUL; u.dst = s1; u.ra = aim; u.rb = aim; end
          default: begin u.op = ROP_CHK; u.ra = s0; u.rb = s1; u.fin = 1'b1; end
        endcase
      end
      COP_ADD, COP_SUB, COP_NEG, COP_ABS, COP_ADDK: begin
        case (c.op)
          COP_ADD:  u.op = ROP_ADD;
          COP_SUB:  u.op = ROP_SUB;
          COP_NEG:  u.op = ROP_NEG;
          COP_ABS:  u.op = ROP_ABS;
          default:  u.op = ROP_ADDK;
        endcase
        if (sub[0]) begin
          u.dst = dim; u.ra = aim; u.rb = bim; u.fin = 1'b1;
        end
      end
      default: begin
        u.op = ROP_NOP; u.fin = 1'b1;
      end
    endcase
    return u;
  endfunction

  function automatic word_t konst(kc_e k, logic im);
    case (k)
      K_JULIA: return im ? K_J_IM : K_J_RE;
      K_F:     return im ? K_F_IM : K_F_RE;
      K_X:     return im ? K_X_IM : K_X_RE;
      default: return '0;
    endcase
  endfunction

  function automatic word_t sat_w(logic signed [WBITS:0] v);
    if (v[WBITS] != v[WBITS-1]) return v[WBITS] ? W_MIN : W_MAX;
    return v[WBITS-1:0];
  endfunction

  function automatic word_t neg_w(word_t a);
    return (a == W_MIN) ? W_MAX : -a;
  endfunction

  function automatic logic signed [WBITS:0] wext(word_t a);
    return {a[WBITS-1], a};
  endfunction

  function automatic logic signed [CBITS-1:0] sat_c(logic signed [SUMW-1:0] v);
    if (!(&v[SUMW-1:CBITS-1]) && (|v[SUMW-1:CBITS-1])) begin
      return v[SUMW-1] ? {1'b1, {(CBITS-1){1'b0}}} : {1'b0, {(CBITS-1){1'b1}}};
    end
    return v[CBITS-1:0];
  endfunction

endpackage

[hw/rtl/efi_mul.sv]
module efi_mul
  import efi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t a_i,
  input  word_t b_i,
  output logic  done_o,
  output word_t res_o
);

  localparam int QW = ACCW - WFRAC;
  localparam logic [QW-1:0] Q_POS = {{(QW-WBITS+1){1'b0}}, {(WBITS-1){1'b1}}};

  logic [2*HALF-1:0] ma_q, mb_q;
  logic              neg_q;
  logic [ACCW-1:0]   acc_q;
  logic [1:0]        cnt_q;
  logic              busy_q, fin_q, done_q;
  word_t             res_q;

  logic [WBITS-1:0]  mag_a, mag_b;
  logic [HALF-1:0]   ah, bh;
  logic [2*HALF-1:0] pp;
  logic [ACCW-1:0]   ppx;
  logic [QW-1:0]     q;
  word_t             sat_res;

  always_comb begin
    mag_a = a_i[WBITS-1] ? -a_i : a_i;
    mag_b = b_i[WBITS-1] ? -b_i : b_i;
    ah = cnt_q[1] ? ma_q[2*HALF-1:HALF] : ma_q[HALF-1:0];
    bh = cnt_q[0] ? mb_q[2*HALF-1:HALF] : mb_q[HALF-1:0];
    pp = ah * bh;
    case (cnt_q)
      2'd0:    ppx = ACCW'(pp);
      2'd3:    ppx = ACCW'(pp) << (2 * HALF);
      default: ppx = ACCW'(pp) << HALF;
    endcase
    // truncate toward zero, then clamp
    q = acc_q[ACCW-1:WFRAC];
    if (neg_q) begin
      sat_res = (q > Q_POS + QW'(1)) ? W_MIN : -q[WBITS-1:0];
    end else begin
      sat_res = (q > Q_POS) ? W_MAX : q[WBITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        ma_q   <= (2*HALF)'(mag_a);
        mb_q   <= (2*HALF)'(mag_b);
        neg_q  <= a_i[WBITS-1] ^ b_i[WBITS-1];
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= acc_q + ppx;
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) begin
        res_q  <= sat_res;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[hw/rtl/escape_time_fractal_iterator_core.sv]
// Escape-time fractal iterator: one pixel word in, one result word out. The
// pixel is mapped to c in Q4.28 from the window registers, then z starts at c
// and the selected rule runs until |z|^2 > 25 or max_depth iterations are
// done; the result carries the pixel position and the iteration count. All
// iteration arithmetic goes through one 48-bit saturating multiplier (four
// 24x24 partial products) and saturating add and subtract logic, driven by
// a small microcoded sequencer over a 16-entry register file. The block
// takes one pixel at a time: in_ready_o is high only when idle. Each pixel
// runs the setup, then per iteration an escape test plus the rule body, in
// which a complex multiply is split into real multiplies, a subtract and an
// add; a final escape test and the delivery of the result close the pixel.
// The reset depth is 64.
module escape_time_fractal_iterator_core
  import efi_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  pix_in_t                 in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output pix_out_t                out_data_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CBITS-1:0]        cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_FETCH, ST_EXEC, ST_MULW, ST_DONE
  } state_e;

  // configuration registers
  logic [TYPE_BITS-1:0]  type_q;
  logic [COUNT_BITS-1:0] depth_q;
  logic [CBITS-1:0]      minr_q, maxi_q;
  logic [CBITS-2:0]      rstep_q, istep_q;

  // sequencer and per-pixel state
  state_e                state_q;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [PC_BITS-1:0]    pc_q;
  logic [2:0]            sub_q;
  logic [2:0]            init_q;
  logic [PRODW-1:0]      prod_q;
  word_t                 cval_q;
  uop_t                  uop_q;

  // register file: z, c, scratch and temporaries as re/im pairs
  logic [WBITS-1:0]      rf_mem [16];
  word_t                 rda_q, rdb_q;
  logic                  rf_we;
  logic [3:0]            rf_wa;
  word_t                 rf_wd;

  cinstr_t               cur_ci;
  uop_t                  uop_d;
  word_t                 alu_res, kval;
  logic signed [WBITS:0] sum_ab, dif_ab, sum_k;
  logic                  esc;
  logic [PC_BITS-1:0]    adv_pc;
  logic [2:0]            adv_sub;
  logic signed [SUMW-1:0] csum;
  logic signed [CBITS-1:0] csat_v;

  logic                  mul_start, mul_done;
  word_t                 mul_res;

  efi_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (rda_q),
    .b_i     (rdb_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // configuration port, to be written only while idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q  <= '0;
      depth_q <= DEPTH_RST;
      minr_q  <= MINR_RST;
      maxi_q  <= MAXI_RST;
      rstep_q <= STEP_RST;
      istep_q <= STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TYPE:  type_q  <= cfg_data_i[TYPE_BITS-1:0];
        CFG_DEPTH: depth_q <= cfg_data_i[COUNT_BITS-1:0];
        CFG_MINR:  minr_q  <= cfg_data_i;
        CFG_MAXI:  maxi_q  <= cfg_data_i;
        CFG_RSTEP: rstep_q <= cfg_data_i[CBITS-2:0];
        CFG_ISTEP: istep_q <= cfg_data_i[CBITS-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_ci = prog(pc_q);
    uop_d  = expand(cur_ci, sub_q);

    // saturating add, subtract and constant add, and the escape test on the sum
    kval   = konst(uop_q.k, uop_q.dst[0]);
    sum_ab = wext(rda_q) + wext(rdb_q);
    dif_ab = wext(rda_q) - wext(rdb_q);
    sum_k  = wext(rda_q) + wext(kval);
    esc    = sum_ab > ESC_LIMIT;
    case (uop_q.op)
      ROP_ADD:  alu_res = sat_w(sum_ab);
      ROP_SUB:  alu_res = sat_w(dif_ab);
      ROP_ADDK: alu_res = sat_w(sum_k);
      ROP_NEG:  alu_res = neg_w(rda_q);
      ROP_ABS:  alu_res = rda_q[WBITS-1] ? neg_w(rda_q) : rda_q;
      default:  alu_res = rda_q;
    endcase

    // next microcode position after the current step
    if (uop_q.fin) begin
      adv_sub = '0;
      adv_pc  = cur_ci.last ? PC_CHK : pc_q + PC_BITS'(1);
    end else begin
      adv_sub = sub_q + 3'd1;
      adv_pc  = pc_q;
    end

    // window mapping: left edge plus column step, top edge minus row step
    if (init_q == 3'd1) begin
      csum = {{(SUMW-CBITS){minr_q[CBITS-1]}}, minr_q} + {2'b00, prod_q};
    end else begin
      csum = {{(SUMW-CBITS){maxi_q[CBITS-1]}}, maxi_q} - {2'b00, prod_q};
    end
    csat_v = sat_c(csum);

    mul_start = (state_q == ST_EXEC) && (uop_q.op == ROP_MUL);

    // single write port
    rf_we = 1'b0;
    rf_wa = uop_q.dst;
    rf_wd = alu_res;
    case (state_q)
      ST_INIT: begin
        rf_wd = cval_q;
        case (init_q)
          3'd2: begin rf_we = 1'b1; rf_wa = {CC, 1'b0}; end
          3'd3: begin rf_we = 1'b1; rf_wa = {CZ, 1'b0}; end
          3'd5: begin rf_we = 1'b1; rf_wa = {CC, 1'b1}; end
          3'd6: begin rf_we = 1'b1; rf_wa = {CZ, 1'b1}; end
          default: rf_we = 1'b0;
        endcase
      end
      ST_EXEC: begin
        rf_we = (uop_q.op == ROP_ADD) || (uop_q.op == ROP_SUB) ||
                (uop_q.op == ROP_ADDK) || (uop_q.op == ROP_NEG) ||
                (uop_q.op == ROP_ABS);
      end
      ST_MULW: begin
        rf_we = mul_done;
        rf_wd = mul_res;
      end
      default: rf_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (state_q == ST_FETCH) begin
      rda_q <= rf_mem[uop_d.ra];
      rdb_q <= rf_mem[uop_d.rb];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      init_q  <= '0;
      pc_q    <= PC_CHK;
      sub_q   <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            px_q    <= in_data_i.pixel_x;
            py_q    <= in_data_i.pixel_y;
            init_q  <= '0;
            state_q <= ST_INIT;
          end
        end
        ST_INIT: begin
          init_q <= init_q + 3'd1;
          case (init_q)
            3'd0: prod_q <= PRODW'(px_q) * PRODW'(rstep_q);
            3'd3: prod_q <= PRODW'(py_q) * PRODW'(istep_q);
            3'd1, 3'd4: begin
              // c enters the wide format shifted up
              cval_q <= {{(WBITS-CBITS-CSHIFT){csat_v[CBITS-1]}}, csat_v,
                         {CSHIFT{1'b0}}};
            end
            3'd6: begin
              pc_q    <= PC_CHK;
              sub_q   <= '0;
              cnt_q   <= '0;
              state_q <= ST_FETCH;
            end
            default: ;
          endcase
        end
        ST_FETCH: begin
          uop_q   <= uop_d;
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          case (uop_q.op)
            ROP_MUL: state_q <= ST_MULW;
            ROP_CHK: begin
              if (esc || (cnt_q >= depth_q)) begin
                state_q <= ST_DONE;
              end else begin
                cnt_q   <= cnt_q + COUNT_BITS'(1);
                pc_q    <= rule_start(type_q);
                sub_q   <= '0;
                state_q <= ST_FETCH;
              end
            end
            default: begin
              pc_q    <= adv_pc;
              sub_q   <= adv_sub;
              state_q <= ST_FETCH;
            end
          endcase
        end
        ST_MULW: begin
          if (mul_done) begin
            pc_q    <= adv_pc;
            sub_q   <= adv_sub;
            state_q <= ST_FETCH;
          end
        end
        ST_DONE: begin
          if (out_ready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);
  assign out_data_o.out_x        = px_q;
  assign out_data_o.out_y        = py_q;
  assign out_data_o.escape_count = cnt_q;

endmodule

[hw/rtl/efi_checker.sv]
`include "escape_time_fractal_iterator_core_macros.svh"

module efi_checker
  import efi_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input pix_out_t out_data_i
);

  // one pixel in flight: no new word while a result waits
  `EFI_ASSERT_NOW(a_busy_while_out, out_valid_i, !in_ready_i)
  // a result never shows up the cycle after a word is taken
  `EFI_ASSERT_NEXT(a_no_instant_out, in_valid_i && in_ready_i, !out_valid_i)
  // a stalled result holds
  `EFI_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(out_data_i))
  // delivering a result frees the block for the next word
  `EFI_ASSERT_NEXT(a_ready_after_out, out_valid_i && out_ready_i, in_ready_i)

endmodule

bind escape_time_fractal_iterator_core efi_checker u_efi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

[dv/escape_time_fractal_iterator_core_test.sv]
`timescale 1ns / 1ps

module escape_time_fractal_iterator_core_test;
  import efi_pkg::*;

  // cycle limit, far above the slowest legal run
  localparam longint CYCLE_LIMIT = 250_000_000;
  localparam int PIX_TARGET  = 1850;
  localparam int QUIET_AFTER = 1650;
  // register index that maps to nothing
  localparam logic [CFG_IDX_BITS-1:0] CFG_NONE = 3'd7;
  // selector value with no rule behind it
  localparam logic [TYPE_BITS-1:0] TYPE_UNUSED = 4'd15;
  localparam longint ESC_BOUND = 25 * (longint'(1) <<< WFRAC);

  typedef struct packed {
    word_t re;
    word_t im;
  } cpx_t;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [CBITS-1:0]        data;
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
    int                      count;  // negative: use the iteration predictor
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pix_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pix_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [CBITS-1:0] cfg_data_i = '0;

  // shadow of the block's registers
  logic [TYPE_BITS-1:0]  sh_rule;
  logic [COUNT_BITS-1:0] sh_depth;
  logic [CBITS-1:0]      sh_minr;
  logic [CBITS-1:0]      sh_maxi;
  logic [CBITS-2:0]      sh_rstep;
  logic [CBITS-2:0]      sh_istep;

  pix_out_t pending_q[$];
  row_t     rows[$];
  int       errors = 0;
  int       pix_sent = 0;
  int       words_seen = 0;
  bit       quiet = 1'b0;
  longint   cycles = 0;

  escape_time_fractal_iterator_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // fixed point arithmetic, Q12.36 with saturation
  // ---------------------------------------------------------------------
  function automatic word_t clamp_w(longint v);
    if (v > longint'(W_MAX)) return W_MAX;
    if (v < longint'(W_MIN)) return W_MIN;
    return word_t'(v);
  endfunction

  // exact product, truncated toward zero, then saturated
  function automatic word_t qmul(word_t a, word_t b);
    logic neg;
    logic [WBITS-1:0] ma, mb;
    logic [2*WBITS-1:0] p, q;
    neg = a[WBITS-1] ^ b[WBITS-1];
    ma = a[WBITS-1] ? WBITS'(-a) : a;
    mb = b[WBITS-1] ? WBITS'(-b) : b;
    p = {{WBITS{1'b0}}, ma} * {{WBITS{1'b0}}, mb};
    q = p >> WFRAC;
    if (neg) begin
      if (q > (2*WBITS)'(longint'(1) <<< (WBITS-1))) return W_MIN;
      return word_t'(-q);
    end
    if (q > (2*WBITS)'(W_MAX)) return W_MAX;
    return word_t'(q);
  endfunction

  function automatic cpx_t c_add(cpx_t a, cpx_t b);
    cpx_t r;
    r.re = clamp_w(longint'(a.re) + longint'(b.re));
    r.im = clamp_w(longint'(a.im) + longint'(b.im));
    return r;
  endfunction

  function automatic cpx_t c_sub(cpx_t a, cpx_t b);
    cpx_t r;
    r.re = clamp_w(longint'(a.re) - longint'(b.re));
    r.im = clamp_w(longint'(a.im) - longint'(b.im));
    return r;
  endfunction

  function automatic cpx_t c_neg(cpx_t a);
    cpx_t r;
    r.re = clamp_w(-longint'(a.re));
    r.im = clamp_w(-longint'(a.im));
    return r;
  endfunction

  function automatic cpx_t c_swap(cpx_t a);
    cpx_t r;
    r.re = a.im;
    r.im = a.re;
    return r;
  endfunction

  function automatic cpx_t c_abs(cpx_t a);
    cpx_t r;
    r.re = a.re[WBITS-1] ? clamp_w(-longint'(a.re)) : a.re;
    r.im = a.im[WBITS-1] ? clamp_w(-longint'(a.im)) : a.im;
    return r;
  endfunction

  function automatic cpx_t c_mul(cpx_t a, cpx_t b);
    cpx_t r;
    r.re = clamp_w(longint'(qmul(a.re, b.re)) - longint'(qmul(a.im, b.im)));
    r.im = clamp_w(longint'(qmul(a.re, b.im)) + longint'(qmul(a.im, b.re)));
    return r;
  endfunction

  function automatic cpx_t c_cube(cpx_t a);
    return c_mul(c_mul(a, a), a);
  endfunction

  function automatic cpx_t mk_k(word_t re, word_t im);
    cpx_t r;
    r.re = re;
    r.im = im;
    return r;
  endfunction

  // one application of the selected rule
  function automatic cpx_t next_z(logic [TYPE_BITS-1:0] rule, cpx_t z, cpx_t c);
    cpx_t kj;
    kj = mk_k(K_J_RE, K_J_IM);
    case (rule_e'(rule))
      RULE_M: return c_add(c_mul(z, z), c);
      RULE_B: return c_add(c_mul(c_abs(z), c_abs(z)), c);
      RULE_J: return c_add(c_mul(z, z), kj);
      RULE_T: return c_add(c_mul(c_cube(z), z), c);
      RULE_S: return c_add(c_cube(c_neg(z)), c_swap(c));
      RULE_V: return c_add(c_mul(c_neg(c_swap(z)), c_neg(c_swap(z))), z);
      RULE_F: return c_add(c_sub(c_mul(c_neg(c_swap(c_abs(z))), c_neg(c_swap(c_abs(z)))),
                                 c_mul(c, c)), mk_k(K_F_RE, K_F_IM));
      RULE_R: return c_sub(c_sub(c_add(c_cube(z), c_mul(z, c_mul(c, c))), c_cube(c)), z);
      RULE_X: return c_add(c_sub(c_mul(z, z), c_cube(z)), mk_k(K_X_RE, K_X_IM));
      RULE_C: return c_add(c_mul(c_cube(z), z), kj);
      default: return z;
    endcase
  endfunction

  // map the pixel into the window, saturate to Q4.28
  function automatic word_t window_pt(logic [CBITS-1:0] edge_v, logic [CBITS-2:0] step_v,
                                      logic [COORD_BITS-1:0] pos, bit down);
    longint v, lim;
    v = longint'($signed(edge_v));
    if (down) v = v - longint'(pos) * longint'(step_v);
    else v = v + longint'(pos) * longint'(step_v);
    lim = longint'(1) <<< (CBITS-1);
    if (v > lim - 1) v = lim - 1;
    if (v < -lim) v = -lim;
    return word_t'(v * 256);
  endfunction

  // escape count of one pixel under the shadow registers
  function automatic pix_out_t escape_result(logic [COORD_BITS-1:0] x,
                                             logic [COORD_BITS-1:0] y);
    cpx_t c, z;
    int n;
    pix_out_t r;
    c.re = window_pt(sh_minr, sh_rstep, x, 1'b0);
    c.im = window_pt(sh_maxi, sh_istep, y, 1'b1);
    z = c;
    n = 0;
    while (n < int'(sh_depth)) begin
      if (longint'(qmul(z.re, z.re)) + longint'(qmul(z.im, z.im)) > ESC_BOUND) break;
      n++;
      z = next_z(sh_rule, z, c);
    end
    r.out_x = x;
    r.out_y = y;
    r.escape_count = COUNT_BITS'(n);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------
  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CBITS-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_TYPE:  sh_rule  = data[TYPE_BITS-1:0];
      CFG_DEPTH: sh_depth = data[COUNT_BITS-1:0];
      CFG_MINR:  sh_minr  = data;
      CFG_MAXI:  sh_maxi  = data;
      CFG_RSTEP: sh_rstep = data[CBITS-2:0];
      CFG_ISTEP: sh_istep = data[CBITS-2:0];
      default: ;  // unknown index, dropped by the block
    endcase
  endtask

  // offer one pixel word; valid stays up after acceptance unless a random input gap follows
  task automatic send_pix(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y, int count);
    pix_out_t e;
    in_valid_i        <= 1'b1;
    in_data_i.pixel_x <= x;
    in_data_i.pixel_y <= y;
    do @(posedge clk_i); while (!in_ready_o);
    e = escape_result(x, y);
    if (count >= 0) e.escape_count = COUNT_BITS'(count);
    pending_q.push_back(e);
    pix_sent++;
    // random input gap
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // drop valid and wait until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    cfg_we_i   <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic void add_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CBITS-1:0] data);
    row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: data, x: '0, y: '0, count: -1};
    rows.push_back(r);
  endfunction

  function automatic void add_pix(int x, int y, int count);
    row_t r;
    r = '{kind: ROW_PIX, idx: '0, data: '0, x: COORD_BITS'(x), y: COORD_BITS'(y),
          count: count};
    rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // result side: random stalls, one long hold-off, in-order check
  // ---------------------------------------------------------------------
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk_i) begin
    pix_out_t e;
    logic rdy;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_seen++;
      if (pending_q.size() == 0) begin
        $error("result word with nothing pending: %p", out_data_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_data_o.out_x !== e.out_x) begin
          $error("out_x expected %0d actual %0d", e.out_x, out_data_o.out_x);
          errors++;
        end
        if (out_data_o.out_y !== e.out_y) begin
          $error("out_y expected %0d actual %0d", e.out_y, out_data_o.out_y);
          errors++;
        end
        if (out_data_o.escape_count !== e.escape_count) begin
          $error("escape_count expected %0d actual %0d (pixel %0d,%0d)",
                 e.escape_count, out_data_o.escape_count, e.out_x, e.out_y);
          errors++;
        end
      end
    end
    // long hold-off once, while the sender keeps offering pixels
    if (!hold_done && words_seen == 60) begin
      hold_done = 1'b1;
      hold_left = 400;
    end
    if (!rst_ni) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    out_ready_i <= rdy;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin
    int n;
    int pick;
    logic [CBITS-1:0] v;
    sh_rule  = RULE_M;
    sh_depth = DEPTH_RST;
    sh_minr  = MINR_RST;
    sh_maxi  = MAXI_RST;
    sh_rstep = STEP_RST;
    sh_istep = STEP_RST;

    // directed rows, reset window first
    add_pix(255, 255, 64);        // near the origin, never escapes
    add_pix(4095, 4095, 0);       // far corner escapes at once
    add_pix(0, 0, -1);
    add_pix(4095, 0, 0);
    add_pix(0, 4095, 0);
    add_cfg(CFG_DEPTH, '0);       // zero depth
    add_pix(255, 255, 0);
    add_pix(4095, 4095, 0);
    add_cfg(CFG_TYPE, CBITS'(TYPE_UNUSED));  // z held, full depth
    add_cfg(CFG_DEPTH, CBITS'(1023));
    add_pix(255, 255, 1023);
    add_cfg(CFG_DEPTH, CBITS'(5));
    add_pix(100, 100, -1);
    add_cfg(CFG_NONE, '1);        // ignored write
    add_pix(255, 255, 5);
    // window overflow in both directions
    add_cfg(CFG_TYPE, CBITS'(RULE_M));
    add_cfg(CFG_DEPTH, CBITS'(DEPTH_RST));
    add_cfg(CFG_MINR, 32'h7fff_ffff);
    add_cfg(CFG_RSTEP, 32'h7fff_ffff);
    add_pix(4095, 0, 0);
    add_cfg(CFG_MAXI, 32'h8000_0000);
    add_cfg(CFG_ISTEP, 32'h7fff_ffff);
    add_pix(0, 4095, 0);
    // each rule once on the default window
    add_cfg(CFG_MINR, MINR_RST);
    add_cfg(CFG_MAXI, MAXI_RST);
    add_cfg(CFG_RSTEP, CBITS'(STEP_RST));
    add_cfg(CFG_ISTEP, CBITS'(STEP_RST));
    for (int r = RULE_M; r <= RULE_C; r++) begin
      add_cfg(CFG_TYPE, CBITS'(r));
      add_pix(200, 190, -1);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(rows[i].idx, rows[i].data);
        cfg_we_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        send_pix(rows[i].x, rows[i].y, rows[i].count);
      end
    end

    // random phases, each on its own register setting
    while (pix_sent < PIX_TARGET) begin
      drain();
      quiet = (pix_sent > QUIET_AFTER);
      write_reg(CFG_TYPE, CBITS'($urandom_range(0, 99) < 85 ? $urandom_range(0, 9)
                                                             : $urandom_range(10, 15)));
      pick = $urandom_range(0, 99);
      if (pick < 70) n = $urandom_range(1, 16);
      else if (pick < 90) n = $urandom_range(17, 100);
      else n = $urandom_range(101, 255);
      write_reg(CFG_DEPTH, CBITS'(n));
      if ($urandom_range(0, 1)) begin
        // window around the interesting part of the plane
        v = CBITS'(-$urandom_range(1 << 28, 5 << 27));
        write_reg(CFG_MINR, v);
        write_reg(CFG_MAXI, CBITS'($urandom_range(0, 3 << 27)));
        write_reg(CFG_RSTEP, CBITS'($urandom_range(0, 1 << 18)));
        write_reg(CFG_ISTEP, CBITS'($urandom_range(0, 1 << 18)));
      end else begin
        write_reg(CFG_MINR, $urandom);
        write_reg(CFG_MAXI, $urandom);
        write_reg(CFG_RSTEP, $urandom_range(0, 3) == 0 ? 32'h7fff_ffff : $urandom >> 1);
        write_reg(CFG_ISTEP, $urandom_range(0, 3) == 0 ? '0 : $urandom >> 1);
      end
      if ($urandom_range(0, 7) == 0) write_reg(CFG_NONE, $urandom);
      cfg_we_i <= 1'b0;
      @(posedge clk_i);
      n = (sh_depth > 100) ? 2 : $urandom_range(20, 60);
      repeat (n) send_pix($urandom_range(0, 4095), $urandom_range(0, 4095), -1);
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[escape_time_fractal_iterator_core.f]
+incdir+hw/rtl
hw/rtl/efi_pkg.sv
hw/rtl/efi_mul.sv
hw/rtl/escape_time_fractal_iterator_core.sv
hw/rtl/efi_checker.sv
dv/escape_time_fractal_iterator_core_test.sv
